// ===== design/md5_pkg.sv =====
// Package with the shared types, constants and step tables of the MD5 engine.
package md5_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PAD,
    ST_COMP,
    ST_DONE
  } md5_state_e;

  typedef struct packed {
    logic        we;
    logic [3:0]  addr;
    logic [31:0] data;
  } md5_wr_t;

  localparam logic [31:0] INIT_A   = 32'h67452301;
  localparam logic [31:0] INIT_B   = 32'hefcdab89;
  localparam logic [31:0] INIT_C   = 32'h98badcfe;
  localparam logic [31:0] INIT_D   = 32'h10325476;
  localparam logic [7:0]  PAD_BYTE = 8'h80;
  localparam logic [31:0] PAD_WORD = 32'h00000080;
  localparam logic [3:0]  LEN_LO_POS = 4'd14;
  localparam logic [3:0]  LEN_HI_POS = 4'd15;
  localparam logic [5:0]  LAST_ROUND = 6'd63;

  function automatic logic [31:0] md5_k(input logic [5:0] r);
    logic [31:0] k;
    unique case (r)
      6'd0:  k = 32'hd76aa478;
      6'd1:  k = 32'he8c7b756;
      6'd2:  k = 32'h242070db;
      6'd3:  k = 32'hc1bdceee;
      6'd4:  k = 32'hf57c0faf;
      6'd5:  k = 32'h4787c62a;
      6'd6:  k = 32'ha8304613;
      6'd7:  k = 32'hfd469501;
      6'd8:  k = 32'h698098d8;
      6'd9:  k = 32'h8b44f7af;
      6'd10: k = 32'hffff5bb1;
      6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122;
      6'd13: k = 32'hfd987193;
      6'd14: k = 32'ha679438e;
      6'd15: k = 32'h49b40821;
      6'd16: k = 32'hf61e2562;
      6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51;
      6'd19: k = 32'he9b6c7aa;
      6'd20: k = 32'hd62f105d;
      6'd21: k = 32'h02441453;
      6'd22: k = 32'hd8a1e681;
      6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6;
      6'd25: k = 32'hc33707d6;
      6'd26: k = 32'hf4d50d87;
      6'd27: k = 32'h455a14ed;
      6'd28: k = 32'ha9e3e905;
      6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9;
      6'd31: k = 32'h8d2a4c8a;
      6'd32: k = 32'hfffa3942;
      6'd33: k = 32'h8771f681;
      6'd34: k = 32'h6d9d6122;
      6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44;
      6'd37: k = 32'h4bdecfa9;
      6'd38: k = 32'hf6bb4b60;
      6'd39: k = 32'hbebfbc70;
      6'd40: k = 32'h289b7ec6;
      6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085;
      6'd43: k = 32'h04881d05;
      6'd44: k = 32'hd9d4d039;
      6'd45: k = 32'he6db99e5;
      6'd46: k = 32'h1fa27cf8;
      6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244;
      6'd49: k = 32'h432aff97;
      6'd50: k = 32'hab9423a7;
      6'd51: k = 32'hfc93a039;
      6'd52: k = 32'h655b59c3;
      6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d;
      6'd55: k = 32'h85845dd1;
      6'd56: k = 32'h6fa87e4f;
      6'd57: k = 32'hfe2ce6e0;
      6'd58: k = 32'ha3014314;
      6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82;
      6'd61: k = 32'hbd3af235;
      6'd62: k = 32'h2ad7d2bb;
      6'd63: k = 32'heb86d391;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] md5_shift(input logic [5:0] r);
    logic [4:0] s;
    unique case ({r[5:4], r[1:0]})
      4'd0:  s = 5'd7;
      4'd1:  s = 5'd12;
      4'd2:  s = 5'd17;
      4'd3:  s = 5'd22;
      4'd4:  s = 5'd5;
      4'd5:  s = 5'd9;
      4'd6:  s = 5'd14;
      4'd7:  s = 5'd20;
      4'd8:  s = 5'd4;
      4'd9:  s = 5'd11;
      4'd10: s = 5'd16;
      4'd11: s = 5'd23;
      4'd12: s = 5'd6;
      4'd13: s = 5'd10;
      4'd14: s = 5'd15;
      4'd15: s = 5'd21;
    endcase
    return s;
  endfunction

  function automatic logic [3:0] md5_gidx(input logic [5:0] r);
    logic [3:0] r4;
    logic [3:0] g;
    r4 = r[3:0];
    unique case (r[5:4])
      2'd0: g = r4;
      2'd1: g = r4 * 4'd5 + 4'd1;
      2'd2: g = r4 * 4'd3 + 4'd5;
      2'd3: g = r4 * 4'd7;
    endcase
    return g;
  endfunction

endpackage

// ===== design/md5_in_if.sv =====
// Input stream interface: one message word per beat.
interface md5_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] msg_word;
  logic [2:0]  byte_count;
  logic        last_item;

  modport source (output valid, output msg_word, output byte_count, output last_item,
                  input ready);
  modport sink (input valid, input msg_word, input byte_count, input last_item,
                output ready);
endinterface

// ===== design/md5_out_if.sv =====
// Output stream interface: one digest word per beat.
interface md5_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic        digest_last;

  modport source (output valid, output digest_word, output digest_last, input ready);
  modport sink (input valid, input digest_word, input digest_last, output ready);
endinterface

// ===== design/md5_buffer.sv =====
// Sixteen-word message block memory with one write port and a registered read port.
module md5_buffer (
  input  logic                clk_i,
  input  md5_pkg::md5_wr_t    wr_i,
  input  logic [3:0]          rd_addr_i,
  output logic [31:0]         rd_data_o
);

  logic [31:0] mem [16];

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem[wr_i.addr] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_o <= mem[rd_addr_i];
  end

endmodule

// ===== design/md5_round.sv =====
// Shared MD5 step unit: computes the new b word of one step.
module md5_round (
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  input  logic [31:0] c_i,
  input  logic [31:0] d_i,
  input  logic [31:0] m_i,
  input  logic [5:0]  round_i,
  output logic [31:0] t_o
);

  logic [31:0] f;
  logic [31:0] sum;
  logic [63:0] rot;

  always_comb begin
    unique case (round_i[5:4])
      2'd0: f = (b_i & c_i) | (~b_i & d_i);
      2'd1: f = (b_i & d_i) | (c_i & ~d_i);
      2'd2: f = b_i ^ c_i ^ d_i;
      2'd3: f = c_i ^ (b_i | ~d_i);
    endcase
  end

  assign sum = a_i + f + m_i + md5_pkg::md5_k(round_i);
  assign rot = {sum, sum} << md5_pkg::md5_shift(round_i);
  assign t_o = b_i + rot[63:32];

endmodule

// ===== design/md5_hash_engine_core.sv =====
// MD5 hash engine top level: input sequencer, padding, compression control and digest output.
//
// The engine takes one 32-bit message word per input beat while it is idle; a word that does
// not complete a block leaves it ready for the next word. The sixteenth word of a block starts
// a compression that runs the 64 MD5 steps through a single shared step unit, one step per
// cycle. After the last word the padding words are written one per cycle and one or two
// further compressions follow. The four digest words then leave as four beats from an output
// register; the next message is accepted while they drain, and a finished digest waits only if
// the previous one has not yet been taken.
module md5_hash_engine_core (
  input  logic      clk_i,
  input  logic      rst_ni,
  md5_in_if.sink    in_i,
  md5_out_if.source out_o
);

  md5_pkg::md5_state_e state_q, state_d;
  logic [3:0]          wp_q, wp_d;
  logic [63:0]         bitlen_q, bitlen_d;
  logic [5:0]          round_q, round_d;
  logic [3:0][31:0]    chain_q, chain_d;
  logic [3:0][31:0]    wv_q, wv_d;
  logic [3:0][31:0]    wv_new;
  logic                pad_q, pad_d;
  logic                lenok_q, lenok_d;
  logic                first_q, first_d;
  logic [3:0][31:0]    dig_q;
  logic [1:0]          oidx_q;
  logic                ovalid_q;
  logic                load_out;
  logic                go_comp;
  logic [2:0]          cnt_sat;
  logic [31:0]         last_word;
  logic [3:0]          rd_addr;
  logic [31:0]         rd_data;
  logic [31:0]         t_word;
  md5_pkg::md5_wr_t    wr;

  md5_buffer u_buffer (
    .clk_i     (clk_i),
    .wr_i      (wr),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  md5_round u_round (
    .a_i     (wv_q[0]),
    .b_i     (wv_q[1]),
    .c_i     (wv_q[2]),
    .d_i     (wv_q[3]),
    .m_i     (rd_data),
    .round_i (round_q),
    .t_o     (t_word)
  );

  // The block word for step r + 1 is fetched while step r runs.
  assign rd_addr = (state_q == md5_pkg::ST_COMP) ? md5_pkg::md5_gidx(round_q + 6'd1)
                                                 : md5_pkg::md5_gidx(6'd0);

  assign wv_new[0] = wv_q[3];
  assign wv_new[1] = t_word;
  assign wv_new[2] = wv_q[1];
  assign wv_new[3] = wv_q[2];

  assign cnt_sat = (in_i.byte_count > 3'd4) ? 3'd4 : in_i.byte_count;

  always_comb begin
    unique case (cnt_sat)
      3'd0:    last_word = md5_pkg::PAD_WORD;
      3'd1:    last_word = {16'h0000, md5_pkg::PAD_BYTE, in_i.msg_word[7:0]};
      3'd2:    last_word = {8'h00, md5_pkg::PAD_BYTE, in_i.msg_word[15:0]};
      3'd3:    last_word = {md5_pkg::PAD_BYTE, in_i.msg_word[23:0]};
      default: last_word = in_i.msg_word;
    endcase
  end

  always_comb begin
    state_d  = state_q;
    wp_d     = wp_q;
    bitlen_d = bitlen_q;
    round_d  = round_q;
    chain_d  = chain_q;
    wv_d     = wv_q;
    pad_d    = pad_q;
    lenok_d  = lenok_q;
    first_d  = first_q;
    load_out = 1'b0;
    go_comp  = 1'b0;
    wr.we    = 1'b0;
    wr.addr  = wp_q;
    wr.data  = '0;
    in_i.ready = 1'b0;
    unique case (state_q)
      md5_pkg::ST_IDLE: begin
        in_i.ready = 1'b1;
        if (in_i.valid) begin
          wr.we = 1'b1;
          wp_d  = wp_q + 4'd1;
          if (!in_i.last_item) begin
            wr.data  = in_i.msg_word;
            bitlen_d = bitlen_q + 64'd32;
            go_comp  = (wp_q == md5_pkg::LEN_HI_POS);
          end else begin
            wr.data  = last_word;
            bitlen_d = bitlen_q + {58'd0, cnt_sat, 3'b000};
            first_d  = (cnt_sat == 3'd4);
            lenok_d  = (cnt_sat != 3'd4) && (wp_q < md5_pkg::LEN_LO_POS);
            pad_d    = 1'b1;
            if (wp_q == md5_pkg::LEN_HI_POS) begin
              go_comp = 1'b1;
            end else begin
              state_d = md5_pkg::ST_PAD;
            end
          end
        end
      end
      md5_pkg::ST_PAD: begin
        wr.we = 1'b1;
        wp_d  = wp_q + 4'd1;
        if (first_q) begin
          wr.data = md5_pkg::PAD_WORD;
          first_d = 1'b0;
          lenok_d = (wp_q < md5_pkg::LEN_LO_POS);
        end else if (lenok_q && (wp_q == md5_pkg::LEN_LO_POS)) begin
          wr.data = bitlen_q[31:0];
        end else if (lenok_q && (wp_q == md5_pkg::LEN_HI_POS)) begin
          wr.data = bitlen_q[63:32];
        end
        go_comp = (wp_q == md5_pkg::LEN_HI_POS);
      end
      md5_pkg::ST_COMP: begin
        wv_d    = wv_new;
        round_d = round_q + 6'd1;
        if (round_q == md5_pkg::LAST_ROUND) begin
          for (int i = 0; i < 4; i++) begin
            chain_d[i] = chain_q[i] + wv_new[i];
          end
          if (!pad_q) begin
            state_d = md5_pkg::ST_IDLE;
          end else if (lenok_q) begin
            state_d = md5_pkg::ST_DONE;
          end else begin
            lenok_d = 1'b1;
            state_d = md5_pkg::ST_PAD;
          end
        end
      end
      md5_pkg::ST_DONE: begin
        if (!ovalid_q) begin
          load_out   = 1'b1;
          chain_d[0] = md5_pkg::INIT_A;
          chain_d[1] = md5_pkg::INIT_B;
          chain_d[2] = md5_pkg::INIT_C;
          chain_d[3] = md5_pkg::INIT_D;
          bitlen_d   = '0;
          pad_d      = 1'b0;
          lenok_d    = 1'b0;
          first_d    = 1'b0;
          state_d    = md5_pkg::ST_IDLE;
        end
      end
    endcase
    if (go_comp) begin
      state_d = md5_pkg::ST_COMP;
      round_d = '0;
      wv_d    = chain_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= md5_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q       <= '0;
      bitlen_q   <= '0;
      round_q    <= '0;
      chain_q[0] <= md5_pkg::INIT_A;
      chain_q[1] <= md5_pkg::INIT_B;
      chain_q[2] <= md5_pkg::INIT_C;
      chain_q[3] <= md5_pkg::INIT_D;
      wv_q       <= '0;
      pad_q      <= 1'b0;
      lenok_q    <= 1'b0;
      first_q    <= 1'b0;
    end else begin
      wp_q     <= wp_d;
      bitlen_q <= bitlen_d;
      round_q  <= round_d;
      chain_q  <= chain_d;
      wv_q     <= wv_d;
      pad_q    <= pad_d;
      lenok_q  <= lenok_d;
      first_q  <= first_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
      oidx_q   <= '0;
    end else if (load_out) begin
      ovalid_q <= 1'b1;
      oidx_q   <= '0;
    end else if (ovalid_q && out_o.ready) begin
      if (oidx_q == 2'd3) begin
        ovalid_q <= 1'b0;
      end
      oidx_q <= oidx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      dig_q <= chain_q;
    end
  end

  assign out_o.valid       = ovalid_q;
  assign out_o.digest_word = dig_q[oidx_q];
  assign out_o.digest_last = (oidx_q == 2'd3);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != md5_pkg::ST_COMP) |-> (round_q == 6'd0))
    else $error("Step counter is nonzero outside a compression.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == md5_pkg::ST_COMP) || (state_q == md5_pkg::ST_DONE)) |-> (wp_q == 4'd0))
    else $error("Compression or digest with a partly filled block.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(ovalid_q) |-> $past(out_o.ready && (oidx_q == 2'd3)))
    else $error("Digest output dropped before its final beat was taken.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |-> !ovalid_q)
    else $error("New digest loaded over one that is still pending.");

endmodule
